// ===== design/kft_pkg.sv =====
`default_nettype none

package kft_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int KEY_W       = 23;
  localparam int FLOOR_W     = 32;
  localparam int STATUS_W    = 3;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_WRITE  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT    = 3'd0,
    ST_MISS   = 3'd1,
    ST_APPEND = 3'd2,
    ST_REMOVE = 3'd3,
    ST_DROP   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_MOVE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [FLOOR_W-1:0] floor;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [FLOOR_W-1:0] found;
    status_t            status;
  } res_t;

endpackage

`default_nettype wire

// ===== design/kft_ram.sv =====
`default_nettype none

module kft_ram #(
  parameter int WIDTH = kft_pkg::ENTRY_W,
  parameter int DEPTH = kft_pkg::ENTRIES_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/kft_ctrl.sv =====
`default_nettype none

module kft_ctrl #(
  parameter int ENTRIES = kft_pkg::ENTRIES_DEF,
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W = $clog2(ENTRIES + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         command,
  input  wire logic [kft_pkg::KEY_W-1:0]    task_id,
  input  wire logic [kft_pkg::FLOOR_W-1:0]  floor_khz,
  output logic                              ram_rd_en,
  output logic [AW-1:0]                     ram_rd_addr,
  input  wire kft_pkg::entry_t              ram_rd_data,
  output logic                              ram_wr_en,
  output logic [AW-1:0]                     ram_wr_addr,
  output kft_pkg::entry_t                   ram_wr_data,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output kft_pkg::res_t                     res,
  output logic [CNT_W-1:0]                  count
);

  kft_pkg::state_t state, state_next;

  kft_pkg::cmd_t                cmd;
  logic [kft_pkg::KEY_W-1:0]    key;
  logic [kft_pkg::FLOOR_W-1:0]  flr;
  logic [CNT_W-1:0]             rd_idx;
  logic                         pend;
  logic [AW-1:0]                pend_idx;
  logic                         hit;
  logic [AW-1:0]                slot;
  logic [kft_pkg::FLOOR_W-1:0]  hit_floor;

  logic             rd_go;
  logic             match;
  logic             is_remove;
  logic             full;
  logic [CNT_W-1:0] last_idx;

  assign rd_go     = rd_idx < count;
  assign match     = pend && (ram_rd_data.key == key);
  assign is_remove = (cmd == kft_pkg::CMD_WRITE) && (flr == '0);
  assign full      = count == CNT_W'(ENTRIES);
  assign last_idx  = count - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kft_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kft_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = kft_pkg::S_SEARCH;
        end
      end
      kft_pkg::S_SEARCH: begin
        // stop on the first match or once the last issued read is compared
        if (match || !rd_go) begin
          state_next = kft_pkg::S_DECIDE;
        end
      end
      kft_pkg::S_DECIDE: begin
        if (is_remove && hit) begin
          state_next = kft_pkg::S_MOVE;
        end else begin
          state_next = kft_pkg::S_RESP;
        end
      end
      kft_pkg::S_MOVE: begin
        state_next = kft_pkg::S_RESP;
      end
      kft_pkg::S_RESP: begin
        if (res_ready) begin
          state_next = kft_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kft_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    ram_rd_en   = 1'b0;
    ram_rd_addr = rd_idx[AW-1:0];
    ram_wr_en   = 1'b0;
    ram_wr_addr = slot;
    ram_wr_data = '{key: key, floor: flr};
    res_valid   = 1'b0;
    unique case (state)
      kft_pkg::S_IDLE: begin
        in_stall = 1'b0;
      end
      kft_pkg::S_SEARCH: begin
        ram_rd_en = rd_go;
      end
      kft_pkg::S_DECIDE: begin
        if (is_remove) begin
          // fetch the last entry to fill the hole
          ram_rd_en   = hit;
          ram_rd_addr = last_idx[AW-1:0];
        end else if (cmd == kft_pkg::CMD_WRITE) begin
          if (hit) begin
            ram_wr_en = 1'b1;
          end else if (!full) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = count[AW-1:0];
          end
        end
      end
      kft_pkg::S_MOVE: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = ram_rd_data;
      end
      kft_pkg::S_RESP: begin
        res_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == kft_pkg::S_DECIDE && !is_remove && cmd == kft_pkg::CMD_WRITE &&
                 !hit && !full) begin
      count <= count + CNT_W'(1);
    end else if (state == kft_pkg::S_MOVE) begin
      count <= last_idx;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      kft_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd    <= kft_pkg::cmd_t'(command);
          key    <= task_id;
          flr    <= floor_khz;
          rd_idx <= '0;
          pend   <= 1'b0;
          hit    <= 1'b0;
        end
      end
      kft_pkg::S_SEARCH: begin
        pend     <= rd_go;
        pend_idx <= rd_idx[AW-1:0];
        if (rd_go) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
        if (match) begin
          hit       <= 1'b1;
          slot      <= pend_idx;
          hit_floor <= ram_rd_data.floor;
        end
      end
      kft_pkg::S_DECIDE: begin
        res.found <= '0;
        if (cmd == kft_pkg::CMD_LOOKUP) begin
          if (hit) begin
            res.found  <= hit_floor;
            res.status <= kft_pkg::ST_HIT;
          end else begin
            res.status <= kft_pkg::ST_MISS;
          end
        end else if (is_remove) begin
          res.status <= hit ? kft_pkg::ST_REMOVE : kft_pkg::ST_DROP;
        end else if (hit) begin
          res.status <= kft_pkg::ST_HIT;
        end else if (!full) begin
          res.status <= kft_pkg::ST_APPEND;
        end else begin
          res.status <= kft_pkg::ST_DROP;
        end
      end
      default: begin
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("entry count beyond table size");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      ($past(state) == kft_pkg::S_DECIDE || $past(state) == kft_pkg::S_MOVE))
    else $error("entry count changed outside an update");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == kft_pkg::S_DECIDE && hit) |-> (CNT_W'(slot) < count))
    else $error("matched slot outside the packed table");

  a_move_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == kft_pkg::S_MOVE) |-> (count != '0))
    else $error("removal on an empty table");

endmodule

`default_nettype wire

// ===== design/keyed_floor_table.sv =====
// flow: an accepted item walks the table through the first match (every entry on a miss),
//   then a decide step, a move step for a removal that hits, and a response to the output register
// items: one at a time; a new item is taken only after the last result enters the output register,
//   and the search walks the single read port of the table memory one entry per cycle
// reset: clears the entry count and control state; table memory is not cleared
//   and needs no clearing pass, so an item can be taken once reset is released
`default_nettype none

module keyed_floor_table #(
  parameter int ENTRIES = kft_pkg::ENTRIES_DEF,
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W = $clog2(ENTRIES + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              command,
  input  wire logic [kft_pkg::KEY_W-1:0]         task_id,
  input  wire logic [kft_pkg::FLOOR_W-1:0]       floor_khz,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [kft_pkg::FLOOR_W-1:0]            found_floor_khz,
  output logic [kft_pkg::STATUS_W-1:0]           status,
  output logic [CNT_W-1:0]                       entries_in_use
);

  logic                          ram_rd_en;
  logic [AW-1:0]                 ram_rd_addr;
  logic [kft_pkg::ENTRY_W-1:0]   ram_rd_bits;
  kft_pkg::entry_t               ram_rd_data;
  logic                          ram_wr_en;
  logic [AW-1:0]                 ram_wr_addr;
  kft_pkg::entry_t               ram_wr_data;
  logic                          res_valid;
  logic                          res_ready;
  kft_pkg::res_t                 res;
  logic [CNT_W-1:0]              count;

  assign ram_rd_data = kft_pkg::entry_t'(ram_rd_bits);

  kft_ram #(
    .WIDTH (kft_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_bits),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  kft_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .task_id     (task_id),
    .floor_khz   (floor_khz),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .count       (count)
  );

  // output register frees the controller while a result waits
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      found_floor_khz <= res.found;
      status          <= res.status;
      entries_in_use  <= count;
    end
  end

endmodule

`default_nettype wire

// ===== tb/keyed_floor_table_tb.sv =====
`timescale 1ns / 100ps

module keyed_floor_table_tb;

  localparam int TABLE_DEPTH = kft_pkg::ENTRIES_DEF;
  localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 20;
  localparam int RANDOM_ITEMS = 400;
  localparam int POOL_SIZE = 96;

  typedef struct {
    kft_pkg::cmd_t               cmd;
    logic [kft_pkg::KEY_W-1:0]   key;
    logic [kft_pkg::FLOOR_W-1:0] flr;
  } floor_cmd_t;

  typedef struct {
    logic [kft_pkg::FLOOR_W-1:0] found;
    kft_pkg::status_t            status;
    logic [CNT_BITS-1:0]         count;
  } floor_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic command = 1'b0;
  logic [kft_pkg::KEY_W-1:0] task_id = '0;
  logic [kft_pkg::FLOOR_W-1:0] floor_khz = '0;
  logic out_stall = 1'b0;
  wire logic in_stall;
  wire logic out_valid;
  wire logic [kft_pkg::FLOOR_W-1:0] found_floor_khz;
  wire logic [kft_pkg::STATUS_W-1:0] status;
  wire logic [CNT_BITS-1:0] entries_in_use;

  keyed_floor_table #(.ENTRIES(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .task_id(task_id),
    .floor_khz(floor_khz),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .found_floor_khz(found_floor_khz),
    .status(status),
    .entries_in_use(entries_in_use)
  );

  // shadow copy of the table
  logic [kft_pkg::KEY_W-1:0] shadow_keys [TABLE_DEPTH];
  logic [kft_pkg::FLOOR_W-1:0] shadow_floors [TABLE_DEPTH];
  int shadow_count = 0;

  floor_cmd_t pending_cmds[$];
  floor_result_t expected_results[$];
  logic [kft_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  int total_items = 1;
  int items_taken = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic floor_result_t apply_floor_cmd(kft_pkg::cmd_t cmd,
                                                    logic [kft_pkg::KEY_W-1:0] key,
                                                    logic [kft_pkg::FLOOR_W-1:0] flr);
    floor_result_t res;
    int slot;
    slot = -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (slot < 0 && shadow_keys[i] == key) slot = i;
    end
    res.found = '0;
    if (cmd == kft_pkg::CMD_LOOKUP) begin
      if (slot >= 0) begin
        res.found = shadow_floors[slot];
        res.status = kft_pkg::ST_HIT;
      end else begin
        res.status = kft_pkg::ST_MISS;
      end
    end else if (flr == '0) begin
      if (slot >= 0) begin
        // last entry fills the hole, which is a self-move when it is the last
        shadow_keys[slot] = shadow_keys[shadow_count - 1];
        shadow_floors[slot] = shadow_floors[shadow_count - 1];
        shadow_count--;
        res.status = kft_pkg::ST_REMOVE;
      end else begin
        res.status = kft_pkg::ST_DROP;
      end
    end else if (slot >= 0) begin
      shadow_floors[slot] = flr;
      res.status = kft_pkg::ST_HIT;
    end else if (shadow_count < TABLE_DEPTH) begin
      shadow_keys[shadow_count] = key;
      shadow_floors[shadow_count] = flr;
      shadow_count++;
      res.status = kft_pkg::ST_APPEND;
    end else begin
      res.status = kft_pkg::ST_DROP;
    end
    res.count = CNT_BITS'(shadow_count);
    return res;
  endfunction

  task automatic add_cmd(kft_pkg::cmd_t cmd, logic [kft_pkg::KEY_W-1:0] key,
                         logic [kft_pkg::FLOOR_W-1:0] flr);
    floor_cmd_t c;
    c.cmd = cmd;
    c.key = key;
    c.flr = flr;
    pending_cmds.push_back(c);
  endtask

  task automatic report_mismatch(string field, logic [kft_pkg::FLOOR_W-1:0] want,
                                 logic [kft_pkg::FLOOR_W-1:0] got);
    $display("[%0t] %s: expected %0h, got %0h", $time, field, want, got);
    error_count++;
  endtask

  function automatic logic [kft_pkg::FLOOR_W-1:0] pick_floor();
    logic [kft_pkg::FLOOR_W-1:0] f;
    case ($urandom_range(0, 9))
      0: f = 32'h1;
      1: f = 32'hFFFF_FFFF;
      2: f = 32'h8000_0000;
      default: f = $urandom;
    endcase
    if (f == '0) f = 32'h1;
    return f;
  endfunction

  // idle percentages follow the progress through the run
  function automatic int sender_idle_pct();
    case (items_taken * 3 / total_items)
      0: return 22;
      1: return 71;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (items_taken * 3 / total_items)
      0: return 71;
      1: return 22;
      default: return 0;
    endcase
  endfunction

  initial begin
    int r;
    int lookup_pct;
    int remove_pct;
    logic [kft_pkg::KEY_W-1:0] k;
    // directed: empty table, extremes, update, removes of last, first and absent
    add_cmd(kft_pkg::CMD_LOOKUP, 23'h0, 32'hFFFF_FFFF);
    add_cmd(kft_pkg::CMD_WRITE, 23'h5, 32'h0);
    add_cmd(kft_pkg::CMD_WRITE, 23'h0, 32'h1);
    add_cmd(kft_pkg::CMD_WRITE, 23'h7F_FFFF, 32'hFFFF_FFFF);
    add_cmd(kft_pkg::CMD_WRITE, 23'h2A_AAAA, 32'h5555_5555);
    add_cmd(kft_pkg::CMD_WRITE, 23'h55_5555, 32'hAAAA_AAAA);
    add_cmd(kft_pkg::CMD_LOOKUP, 23'h0, 32'h0);
    add_cmd(kft_pkg::CMD_LOOKUP, 23'h7F_FFFF, 32'h1234_5678);
    add_cmd(kft_pkg::CMD_LOOKUP, 23'h12_3456, 32'h0);
    add_cmd(kft_pkg::CMD_WRITE, 23'h0, 32'h8000_0000);
    add_cmd(kft_pkg::CMD_LOOKUP, 23'h0, 32'hFFFF_FFFF);
    add_cmd(kft_pkg::CMD_WRITE, 23'h55_5555, 32'h0);
    add_cmd(kft_pkg::CMD_WRITE, 23'h55_5555, 32'h0);
    add_cmd(kft_pkg::CMD_WRITE, 23'h0, 32'h0);
    add_cmd(kft_pkg::CMD_LOOKUP, 23'h2A_AAAA, 32'h0);
    add_cmd(kft_pkg::CMD_LOOKUP, 23'h0, 32'h0);
    add_cmd(kft_pkg::CMD_LOOKUP, 23'h7F_FFFF, 32'h0);
    add_cmd(kft_pkg::CMD_WRITE, 23'h7F_FFFF, 32'h0);
    add_cmd(kft_pkg::CMD_WRITE, 23'h2A_AAAA, 32'h0);
    add_cmd(kft_pkg::CMD_LOOKUP, 23'h7F_FFFF, 32'h0);

    // pool larger than the table so that growth reaches a full table
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = kft_pkg::KEY_W'($urandom);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case (i / 100)
        0: begin lookup_pct = 15; remove_pct = 5; end
        1: begin lookup_pct = 30; remove_pct = 10; end
        2: begin lookup_pct = 20; remove_pct = 65; end
        default: begin lookup_pct = 34; remove_pct = 33; end
      endcase
      if ($urandom_range(0, 9) == 0) k = kft_pkg::KEY_W'($urandom);
      else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      r = $urandom_range(0, 99);
      if (r < lookup_pct) add_cmd(kft_pkg::CMD_LOOKUP, k, $urandom);
      else if (r < lookup_pct + remove_pct) add_cmd(kft_pkg::CMD_WRITE, k, '0);
      else add_cmd(kft_pkg::CMD_WRITE, k, pick_floor());
    end
    total_items = pending_cmds.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_cmds.size() == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  always @(posedge clk) begin : drive
    floor_cmd_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_floor_cmd(kft_pkg::cmd_t'(command), task_id,
                                                   floor_khz));
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          nxt = pending_cmds.pop_front();
          command <= nxt.cmd;
          task_id <= nxt.key;
          floor_khz <= nxt.flr;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : observe
    floor_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no item pending", '0, found_floor_khz);
        end else begin
          want = expected_results.pop_front();
          if (found_floor_khz !== want.found)
            report_mismatch("found_floor_khz", want.found, found_floor_khz);
          if (status !== want.status)
            report_mismatch("status", kft_pkg::FLOOR_W'(want.status),
                            kft_pkg::FLOOR_W'(status));
          if (entries_in_use !== want.count)
            report_mismatch("entries_in_use", kft_pkg::FLOOR_W'(want.count),
                            kft_pkg::FLOOR_W'(entries_in_use));
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < STALL_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
